// File: hdl/arsub_pkg.sv
`timescale 1ns / 1ps

package arsub_pkg;

  // Operation codes carried by an input request.
  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_INSERT   = 2'd1;
  localparam logic [1:0] OP_SUBTRACT = 2'd2;

  // Status codes of a result.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One input request.
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic        end_of_list;
  } arsub_req_t;

  // One result.
  typedef struct packed {
    logic [31:0] piece_low;
    logic [31:0] piece_high;
    logic        kept;
    logic        last;
    logic        status;
  } arsub_rsp_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SUB,
    S_FIN,
    S_RESP
  } arsub_state_t;

endpackage

// File: hdl/arsub_ram.sv
`timescale 1ns / 1ps

module arsub_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and one registered read port. The read data holds
  // while no read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/address_range_subtractor.sv
`timescale 1ns / 1ps

// Address range subtractor.
// Requests enter on in_valid/in_ready/in_req and results leave on
// out_valid/out_ready/out_rsp. A clear, insert or unused-code request gives
// one result with last set; status flags an insert dropped for a full table.
// A subtract request gives each surviving piece of its range in ascending
// order, last set on the final one, or a single result with kept low.
// The removal table lives in one RAM with a registered read port.
// After the accepting cycle, a subtract has the sequencer skip the
// removal entries below the range, examine each entry inside it, then
// queue any surviving tail piece and release the final result.
// Pieces leave while entries are examined, so they add no delay unless
// the receiver stalls. An insert moves each larger entry up one slot to
// open its slot, and a clear resets the entry count and scan cursor.
// One request is in flight at a time; the next is taken once the last
// result sits in the output register. After reset the table is empty
// and the scan cursor is zero; no clearing pass is needed. When the
// receiver stalls, the result waits in the output register and the
// sequencer holds.
module address_range_subtractor
  import arsub_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  arsub_req_t in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output arsub_rsp_t out_rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);

  arsub_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          skip_r, skip_nxt;
  logic [31:0]   lo_r, lo_nxt;
  logic [31:0]   hi_r, hi_nxt;
  logic [32:0]   start_r, start_nxt;
  logic          eol_r, eol_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [31:0]   pend_lo_r, pend_lo_nxt;
  logic [31:0]   pend_hi_r, pend_hi_nxt;
  logic          status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  arsub_rsp_t    out_rsp_r, out_rsp_nxt;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [63:0]   ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [63:0]   ram_rd_data;

  // Each entry holds the high bound over the low bound.
  arsub_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Shared decode of the entry just read and of the working range.
  logic [31:0]   rlo, rhi;
  logic [32:0]   rhi_inc, end_ext, start_adv;
  logic          out_free, accept, table_full, idx_in;
  logic          skip_more, hit_end, new_piece, sub_stall, tail, ins_place;
  logic [CW-1:0] idx_inc, idx_dec, idx_dec2, count_dec;

  assign rlo        = ram_rd_data[31:0];
  assign rhi        = ram_rd_data[63:32];
  assign rhi_inc    = {1'b0, rhi} + 33'd1;
  assign end_ext    = {1'b0, hi_r};
  assign start_adv  = (rhi_inc > start_r) ? rhi_inc : start_r;
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = (count_r >= CW'(TABLE_DEPTH));
  assign idx_in     = (idx_r < count_r);
  assign skip_more  = idx_in && (rhi < lo_r);
  assign hit_end    = !idx_in || (rlo > hi_r);
  assign new_piece  = ({1'b0, rlo} > start_r);
  assign sub_stall  = new_piece && pend_valid_r && !out_free;
  assign tail       = (start_r <= end_ext);
  assign ins_place  = (idx_r == '0) || (rlo <= lo_r);
  assign idx_inc    = idx_r + CW'(1);
  assign idx_dec    = idx_r - CW'(1);
  assign idx_dec2   = idx_r - CW'(2);
  assign count_dec  = count_r - CW'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req.operation)
            OP_INSERT:   state_nxt = table_full ? S_RESP : S_INS;
            OP_SUBTRACT: state_nxt = S_SUB;
            default:     state_nxt = S_RESP;
          endcase
        end
      end
      S_INS: begin
        if (ins_place) begin
          state_nxt = S_RESP;
        end
      end
      S_SUB: begin
        if (!skip_r) begin
          if (hit_end) begin
            state_nxt = S_FIN;
          end else if (!sub_stall && (start_adv > end_ext)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!tail && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, table access and result loading.
  always_comb begin
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    idx_nxt        = idx_r;
    skip_nxt       = skip_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    start_nxt      = start_r;
    eol_nxt        = eol_r;
    pend_valid_nxt = pend_valid_r;
    pend_lo_nxt    = pend_lo_r;
    pend_hi_nxt    = pend_hi_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rsp_nxt    = out_rsp_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r[AW-1:0];
    ram_wr_data    = {hi_r, lo_r};
    ram_rd_en      = 1'b0;
    ram_rd_addr    = idx_r[AW-1:0];

    case (state_r)
      // Take a request and prime the first table read.
      S_IDLE: begin
        if (accept) begin
          lo_nxt         = in_req.range_low;
          hi_nxt         = in_req.range_high;
          eol_nxt        = in_req.end_of_list;
          start_nxt      = {1'b0, in_req.range_low};
          skip_nxt       = 1'b1;
          pend_valid_nxt = 1'b0;
          status_nxt     = STATUS_OK;
          case (in_req.operation)
            OP_CLEAR: begin
              count_nxt  = '0;
              cursor_nxt = '0;
            end
            OP_INSERT: begin
              if (table_full) begin
                status_nxt = STATUS_FULL;
              end else begin
                idx_nxt     = count_r;
                ram_rd_en   = (count_r != '0);
                ram_rd_addr = count_dec[AW-1:0];
              end
            end
            OP_SUBTRACT: begin
              idx_nxt     = cursor_r;
              ram_rd_en   = 1'b1;
              ram_rd_addr = cursor_r[AW-1:0];
            end
            default: begin
              status_nxt = STATUS_OK;
            end
          endcase
        end
      end

      // Walk down from the top, moving each larger entry up one slot
      // until the new range's place is found.
      S_INS: begin
        ram_wr_en = 1'b1;
        if (ins_place) begin
          ram_wr_data = {hi_r, lo_r};
          count_nxt   = count_r + CW'(1);
          cursor_nxt  = '0;
        end else begin
          ram_wr_data = ram_rd_data;
          idx_nxt     = idx_dec;
          ram_rd_en   = (idx_dec != '0);
          ram_rd_addr = idx_dec2[AW-1:0];
        end
      end

      // Skip entries below the range, then cut the range entry by entry.
      // A found piece is held back one step so that the last flag can be
      // set on whichever piece turns out to be final.
      S_SUB: begin
        if (skip_r) begin
          if (skip_more) begin
            idx_nxt     = idx_inc;
            cursor_nxt  = idx_inc;
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_inc[AW-1:0];
          end else begin
            skip_nxt = 1'b0;
          end
        end else if (!hit_end && !sub_stall) begin
          if (new_piece) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{pend_lo_r, pend_hi_r, 1'b1, 1'b0, STATUS_OK};
            end
            pend_valid_nxt = 1'b1;
            pend_lo_nxt    = start_r[31:0];
            pend_hi_nxt    = rlo - 32'd1;
          end
          start_nxt = start_adv;
          if (start_adv <= end_ext) begin
            idx_nxt     = idx_inc;
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_inc[AW-1:0];
          end
        end
      end

      // Queue the tail piece if one survives, then release the held piece
      // as the final result, or a not-kept result if nothing survived.
      S_FIN: begin
        if (tail) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{pend_lo_r, pend_hi_r, 1'b1, 1'b0, STATUS_OK};
            end
            pend_valid_nxt = 1'b1;
            pend_lo_nxt    = start_r[31:0];
            pend_hi_nxt    = hi_r;
            start_nxt      = end_ext + 33'd1;
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_rsp_nxt = '{pend_lo_r, pend_hi_r, 1'b1, 1'b1, STATUS_OK};
          end else begin
            out_rsp_nxt = '{32'd0, 32'd0, 1'b0, 1'b1, STATUS_OK};
          end
          pend_valid_nxt = 1'b0;
          if (eol_r) begin
            cursor_nxt = '0;
          end
        end
      end

      // Single result of a clear, insert or unused code.
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{32'd0, 32'd0, 1'b0, 1'b1, status_r};
        end
      end

      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cursor_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cursor_r     <= cursor_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    skip_r    <= skip_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    start_r   <= start_nxt;
    eol_r     <= eol_nxt;
    pend_lo_r <= pend_lo_nxt;
    pend_hi_r <= pend_hi_nxt;
    status_r  <= status_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The scan cursor never passes the filled part of the table.
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("scan cursor beyond entry count");

  // The table is written only while an insert shifts entries.
  a_write_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_INS))
    else $error("table written outside an insert");

  // A held piece exists only while a subtract is in progress.
  a_pend_in_subtract: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_SUB || state_r == S_FIN))
    else $error("held piece outside a subtract");

  // A completed insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS && ins_place) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not add one entry");

endmodule

// File: tb/tb_address_range_subtractor.sv
`timescale 1ns / 1ps

module tb_address_range_subtractor;
  import arsub_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A queued request, optionally held back until all results are in.
  typedef struct {
    arsub_req_t req;
    bit         drain_first;
  } pending_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  arsub_req_t in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  arsub_rsp_t out_rsp;

  pending_req_t pending_reqs[$];
  arsub_rsp_t   expected_pieces[$];

  // Shadow copy of the removal table and the scan cursor.
  logic [31:0] removal_lo[TABLE_DEPTH];
  logic [31:0] removal_hi[TABLE_DEPTH];
  int          removal_count = 0;
  int          scan_pos = 0;

  int n_sent = 0;
  int n_counted = 0;
  int total_reqs = 1;
  int n_errors = 0;
  int tx_idle_pct;
  int rx_idle_pct;

  address_range_subtractor #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always #1 clk = ~clk;

  // Adds an offset to an address, stopping at the top address.
  function automatic logic [31:0] add_sat(input logic [31:0] a, input int unsigned b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void push_req(input logic [1:0] op, input logic [31:0] lo,
                                   input logic [31:0] hi, input logic eol, input bit drain);
    pending_req_t p;
    p.req.operation   = op;
    p.req.range_low   = lo;
    p.req.range_high  = hi;
    p.req.end_of_list = eol;
    p.drain_first     = drain;
    pending_reqs.push_back(p);
    if (op != OP_UNUSED) n_counted++;
  endfunction

  // Works out the results of one accepted request and updates the shadow state.
  function automatic void predict_request(input arsub_req_t r);
    arsub_rsp_t  rsp;
    arsub_rsp_t  pieces[$];
    logic [32:0] start_a;
    logic [32:0] end_a;
    logic [32:0] next_a;
    int          idx;
    int          slot;
    rsp      = '0;
    rsp.last = 1'b1;
    case (r.operation)
      OP_CLEAR: begin
        removal_count = 0;
        scan_pos      = 0;
        expected_pieces.push_back(rsp);
      end
      OP_INSERT: begin
        if (removal_count >= TABLE_DEPTH) begin
          rsp.status = STATUS_FULL;
        end else begin
          // New entry goes after every entry with an equal or lower low bound.
          slot = 0;
          while (slot < removal_count && removal_lo[slot] <= r.range_low) slot++;
          for (idx = removal_count; idx > slot; idx--) begin
            removal_lo[idx] = removal_lo[idx - 1];
            removal_hi[idx] = removal_hi[idx - 1];
          end
          removal_lo[slot] = r.range_low;
          removal_hi[slot] = r.range_high;
          removal_count++;
          scan_pos = 0;
        end
        expected_pieces.push_back(rsp);
      end
      OP_SUBTRACT: begin
        start_a = {1'b0, r.range_low};
        end_a   = {1'b0, r.range_high};
        if (scan_pos > removal_count) scan_pos = 0;
        while (scan_pos < removal_count && removal_hi[scan_pos] < r.range_low) scan_pos++;
        // Walk the overlapping entries; the start never wraps past the top.
        for (idx = scan_pos; idx < removal_count; idx++) begin
          if ({1'b0, removal_lo[idx]} > end_a) break;
          if ({1'b0, removal_lo[idx]} > start_a) begin
            rsp            = '0;
            rsp.piece_low  = start_a[31:0];
            rsp.piece_high = removal_lo[idx] - 32'd1;
            rsp.kept       = 1'b1;
            pieces.push_back(rsp);
          end
          next_a = {1'b0, removal_hi[idx]} + 33'd1;
          if (next_a > start_a) start_a = next_a;
          if (start_a > end_a) break;
        end
        if (start_a <= end_a) begin
          rsp            = '0;
          rsp.piece_low  = start_a[31:0];
          rsp.piece_high = end_a[31:0];
          rsp.kept       = 1'b1;
          pieces.push_back(rsp);
        end
        if (r.end_of_list) scan_pos = 0;
        if (pieces.size() == 0) begin
          rsp      = '0;
          rsp.last = 1'b1;
          expected_pieces.push_back(rsp);
        end else begin
          for (idx = 0; idx < pieces.size(); idx++) begin
            rsp      = pieces[idx];
            rsp.last = (idx == pieces.size() - 1);
            expected_pieces.push_back(rsp);
          end
        end
      end
      default: expected_pieces.push_back(rsp);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %h, got %h", name, exp_val, got_val);
      n_errors++;
    end
  endfunction

  // Idle rates: sender light and receiver heavy, then swapped, then none.
  always_comb begin
    if (n_sent < total_reqs / 3) begin
      tx_idle_pct = 22;
      rx_idle_pct = 50;
    end else if (n_sent < 2 * total_reqs / 3) begin
      tx_idle_pct = 50;
      rx_idle_pct = 22;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Request driver: predicts on acceptance, then offers the next request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_req);
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].drain_first && expected_pieces.size() > 0) &&
            $urandom_range(99, 0) >= tx_idle_pct) begin
          in_req   <= pending_reqs[0].req;
          in_valid <= 1'b1;
          n_sent   <= n_sent + 1;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    arsub_rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pieces.size() == 0) begin
        $error("unexpected result: piece %h..%h kept %b last %b status %b",
               out_rsp.piece_low, out_rsp.piece_high, out_rsp.kept, out_rsp.last,
               out_rsp.status);
        n_errors++;
      end else begin
        exp_rsp = expected_pieces.pop_front();
        check_field("piece_low", exp_rsp.piece_low, out_rsp.piece_low);
        check_field("piece_high", exp_rsp.piece_high, out_rsp.piece_high);
        check_field("kept", 32'(exp_rsp.kept), 32'(out_rsp.kept));
        check_field("last", 32'(exp_rsp.last), 32'(out_rsp.last));
        check_field("status", 32'(exp_rsp.status), 32'(out_rsp.status));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          kind;
    int          k;
    int          m;
    int          j;
    logic [31:0] base;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    logic [32:0] pos;
    logic        last_one;

    // Empty table, inverted input range, unused operation code.
    push_req(OP_SUBTRACT, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(OP_SUBTRACT, 32'h5, 32'h4, 1'b1, 1'b0);
    push_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // Removals: one at the top address, a duplicate low bound, an inverted one.
    push_req(OP_INSERT, 32'h10, 32'h1F, 1'b0, 1'b0);
    push_req(OP_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(OP_INSERT, 32'h8, 32'h8, 1'b0, 1'b0);
    push_req(OP_INSERT, 32'h10, 32'h30, 1'b0, 1'b0);
    push_req(OP_INSERT, 32'h200, 32'h100, 1'b0, 1'b0);
    push_req(OP_SUBTRACT, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_req(OP_SUBTRACT, 32'h12, 32'h18, 1'b0, 1'b0);
    push_req(OP_SUBTRACT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(OP_SUBTRACT, 32'h20, 32'h40, 1'b1, 1'b0);
    // Clear after the pipeline has drained, then a single-address removal.
    push_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_req(OP_SUBTRACT, 32'h1000, 32'h2000, 1'b1, 1'b0);
    push_req(OP_INSERT, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(OP_SUBTRACT, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(OP_SUBTRACT, 32'h0, 32'h1, 1'b1, 1'b0);
    push_req(OP_UNUSED, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(OP_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);

    // Fill the table in descending order, overflow it, then cut every gap.
    base = $urandom_range(32'hFFFF_0000, 0);
    push_req(OP_CLEAR, $urandom, $urandom, 1'b0, 1'b1);
    for (j = TABLE_DEPTH; j >= 0; j--) begin
      push_req(OP_INSERT, base + 8 * j + 2, base + 8 * j + 5, 1'($urandom_range(1, 0)),
               1'b0);
    end
    push_req(OP_SUBTRACT, base, base + 300, 1'b1, 1'b0);

    while (n_counted < 100) begin
      case ($urandom_range(9, 0))
        0: base = 32'h0;
        1, 2: base = 32'hFFFF_FFFF - $urandom_range(6000, 0);
        default: base = $urandom;
      endcase
      kind = $urandom_range(99, 0);
      if (kind < 65) begin
        // Well-formed: optional clear, a few removals, one ascending list.
        if ($urandom_range(1, 0)) begin
          push_req(OP_CLEAR, $urandom, $urandom, 1'($urandom_range(1, 0)),
                   $urandom_range(9, 0) == 0);
        end
        k = $urandom_range(6, 0);
        for (j = 0; j < k; j++) begin
          lo = add_sat(base, $urandom_range(4000, 0));
          hi = add_sat(lo, $urandom_range(300, 0));
          case ($urandom_range(9, 0))
            0: begin
              t  = lo;
              lo = hi;
              hi = t;
            end
            1: hi = 32'hFFFF_FFFF;
            default: ;
          endcase
          push_req(OP_INSERT, lo, hi, 1'($urandom_range(1, 0)), 1'b0);
        end
        m   = $urandom_range(6, 1);
        pos = {1'b0, base};
        for (j = 0; j < m; j++) begin
          lo = add_sat(pos[31:0], $urandom_range(400, 0));
          if ($urandom_range(19, 0) == 0 && lo != 32'h0) begin
            hi = lo - 32'd1;
          end else begin
            hi = add_sat(lo, $urandom_range(500, 0));
          end
          pos      = {1'b0, hi} + 33'd1;
          last_one = (j == m - 1) || pos[32];
          push_req(OP_SUBTRACT, lo, hi, last_one, 1'b0);
          if (last_one) break;
        end
      end else if (kind < 80) begin
        // Noise: any operation code with fully random fields.
        k = $urandom_range(4, 1);
        for (j = 0; j < k; j++) begin
          push_req(2'($urandom_range(3, 0)), $urandom, $urandom,
                   1'($urandom_range(1, 0)), 1'b0);
        end
      end else begin
        // Broken lists: unordered, overlapping ranges with random list ends.
        k = $urandom_range(5, 1);
        for (j = 0; j < k; j++) begin
          lo = add_sat(base, $urandom_range(4000, 0));
          hi = add_sat(lo, $urandom_range(600, 0));
          push_req(OP_SUBTRACT, lo, hi, $urandom_range(3, 0) == 0, 1'b0);
        end
      end
    end
    total_reqs = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (expected_pieces.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("address_range_subtractor: match");
    end else begin
      $display("address_range_subtractor: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_000_000;
    $display("address_range_subtractor: mismatch");
    $finish;
  end

endmodule
